/* rtl/core/tdq_pkg.sv */
// ----------------------------------------------------------------------------
// tdq_pkg: shared types for the tree distance query block
// Request and result payloads, opcodes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tdq_pkg;

	localparam logic [1:0] OP_WR_DEPTH = 2'd0;
	localparam logic [1:0] OP_WR_ANC   = 2'd1;
	localparam logic [1:0] OP_QUERY    = 2'd2;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] node_a;
		logic [15:0] node_b;
		logic [3:0]  lift_level;
		logic [15:0] write_value;
	} req_t;

	typedef struct packed {
		logic [16:0] distance;
		logic [15:0] common_ancestor;
	} res_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_RED1,
		S_RED2,
		S_WRITE,
		S_RDA,
		S_RDB,
		S_SWAP,
		S_L1A,
		S_L1D,
		S_L1C,
		S_L2A,
		S_L2B,
		S_L2C,
		S_FA,
		S_FB,
		S_DL,
		S_DC
	} state_t;

	typedef enum logic [1:0] {
		DS_A,
		DS_B,
		DS_ANC,
		DS_X
	} dsel_t;

	typedef enum logic {
		AS_X,
		AS_Y
	} asel_t;

	typedef struct packed {
		logic  load_req;
		logic  wr_depth;
		logic  wr_anc;
		logic  rd_depth;
		dsel_t dsel;
		logic  rd_anc;
		asel_t asel;
		logic  cap_da;
		logic  swap;
		logic  lvl_init;
		logic  lvl_dec;
		logic  p_cap;
		logic  lift1;
		logic  lift2;
		logic  parent;
		logic  finish;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       lvl_ok;
		logic       lvl_zero;
		logic       xy_ne;
	} stat_t;

endpackage

/* rtl/core/tdq_ram.sv */
// ----------------------------------------------------------------------------
// tdq_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tdq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/core/tdq_node_mod.sv */
// ----------------------------------------------------------------------------
// tdq_node_mod: node number reduction modulo NODES
// Two-stage reciprocal multiply: quotient, then remainder.
// ----------------------------------------------------------------------------
module tdq_node_mod #(
	parameter int NODES = 65536
) (
	input  logic                                     clk,
	input  logic [15:0]                              value,
	output logic [((NODES > 1) ? $clog2(NODES) : 1)-1:0] node
);

	localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
	localparam longint unsigned RECIP = ((64'd1 << 32) + NODES - 1) / NODES;

	logic [47:0] prod_w;
	logic [15:0] q_s1;
	logic [15:0] v_s1;
	logic [32:0] rem_w;

	assign prod_w = 48'(value) * 48'(RECIP);

	always_ff @(posedge clk) begin
		q_s1 <= prod_w[47:32];
		v_s1 <= value;
	end

	assign rem_w = 33'(v_s1) - 33'(q_s1) * 33'(NODES);

	always_ff @(posedge clk) begin
		node <= rem_w[NW-1:0];
	end

endmodule

/* rtl/core/tdq_ctrl.sv */
// ----------------------------------------------------------------------------
// tdq_ctrl: sequencing controller
// Steps loads and the two lifting passes of a query over the datapath.
// ----------------------------------------------------------------------------
module tdq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  tdq_pkg::stat_t  stat,
	output tdq_pkg::cmd_t   cmd
);

	tdq_pkg::state_t state_q;
	tdq_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tdq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tdq_pkg::S_IDLE: begin
				if (start) state_d = tdq_pkg::S_RED1;
			end
			tdq_pkg::S_RED1: state_d = tdq_pkg::S_RED2;
			tdq_pkg::S_RED2: begin
				unique case (stat.op) inside
					tdq_pkg::OP_WR_DEPTH, tdq_pkg::OP_WR_ANC: state_d = tdq_pkg::S_WRITE;
					tdq_pkg::OP_QUERY: state_d = tdq_pkg::S_RDA;
					default: state_d = tdq_pkg::S_IDLE;
				endcase
			end
			tdq_pkg::S_WRITE: state_d = tdq_pkg::S_IDLE;
			tdq_pkg::S_RDA:   state_d = tdq_pkg::S_RDB;
			tdq_pkg::S_RDB:   state_d = tdq_pkg::S_SWAP;
			tdq_pkg::S_SWAP:  state_d = tdq_pkg::S_L1A;
			tdq_pkg::S_L1A:   state_d = tdq_pkg::S_L1D;
			tdq_pkg::S_L1D:   state_d = tdq_pkg::S_L1C;
			tdq_pkg::S_L1C: begin
				state_d = stat.lvl_zero ? tdq_pkg::S_L2A : tdq_pkg::S_L1A;
			end
			tdq_pkg::S_L2A:   state_d = tdq_pkg::S_L2B;
			tdq_pkg::S_L2B:   state_d = tdq_pkg::S_L2C;
			tdq_pkg::S_L2C: begin
				state_d = stat.lvl_zero ? tdq_pkg::S_FA : tdq_pkg::S_L2A;
			end
			tdq_pkg::S_FA: begin
				state_d = stat.xy_ne ? tdq_pkg::S_FB : tdq_pkg::S_DL;
			end
			tdq_pkg::S_FB:    state_d = tdq_pkg::S_DL;
			tdq_pkg::S_DL:    state_d = tdq_pkg::S_DC;
			tdq_pkg::S_DC:    state_d = tdq_pkg::S_IDLE;
			default:          state_d = tdq_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			tdq_pkg::S_IDLE: begin
				busy         = 1'b0;
				cmd.load_req = start;
			end
			tdq_pkg::S_WRITE: begin
				cmd.wr_depth = (stat.op == tdq_pkg::OP_WR_DEPTH);
				cmd.wr_anc   = (stat.op == tdq_pkg::OP_WR_ANC) && stat.lvl_ok;
			end
			tdq_pkg::S_RDA: begin
				cmd.rd_depth = 1'b1;
				cmd.dsel     = tdq_pkg::DS_A;
			end
			tdq_pkg::S_RDB: begin
				cmd.rd_depth = 1'b1;
				cmd.dsel     = tdq_pkg::DS_B;
				cmd.cap_da   = 1'b1;
			end
			tdq_pkg::S_SWAP: begin
				cmd.swap     = 1'b1;
				cmd.lvl_init = 1'b1;
			end
			tdq_pkg::S_L1A: begin
				cmd.rd_anc = 1'b1;
				cmd.asel   = tdq_pkg::AS_X;
			end
			tdq_pkg::S_L1D: begin
				cmd.rd_depth = 1'b1;
				cmd.dsel     = tdq_pkg::DS_ANC;
				cmd.p_cap    = 1'b1;
			end
			tdq_pkg::S_L1C: begin
				cmd.lift1    = 1'b1;
				cmd.lvl_init = stat.lvl_zero;
				cmd.lvl_dec  = !stat.lvl_zero;
			end
			tdq_pkg::S_L2A: begin
				cmd.rd_anc = 1'b1;
				cmd.asel   = tdq_pkg::AS_X;
			end
			tdq_pkg::S_L2B: begin
				cmd.rd_anc = 1'b1;
				cmd.asel   = tdq_pkg::AS_Y;
				cmd.p_cap  = 1'b1;
			end
			tdq_pkg::S_L2C: begin
				cmd.lift2   = 1'b1;
				cmd.lvl_dec = !stat.lvl_zero;
			end
			tdq_pkg::S_FA: begin
				cmd.rd_anc = stat.xy_ne;
				cmd.asel   = tdq_pkg::AS_X;
			end
			tdq_pkg::S_FB: begin
				cmd.parent = 1'b1;
			end
			tdq_pkg::S_DL: begin
				cmd.rd_depth = 1'b1;
				cmd.dsel     = tdq_pkg::DS_X;
			end
			tdq_pkg::S_DC: begin
				cmd.finish = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	a_finish_single: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> !cmd.finish)
		else $error("finish held for two cycles");

	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_req |=> busy)
		else $error("not busy after accepting a request");

	a_finish_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> $past(state_q == tdq_pkg::S_DL))
		else $error("finish without a preceding depth read");

endmodule

/* rtl/core/tdq_datapath.sv */
// ----------------------------------------------------------------------------
// tdq_datapath: depth store, ancestor table and lifting registers
// Holds the working nodes, level counter and result register.
// ----------------------------------------------------------------------------
module tdq_datapath #(
	parameter int NODES  = 65536,
	parameter int LEVELS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  tdq_pkg::cmd_t  cmd,
	input  tdq_pkg::req_t  req_in,
	output tdq_pkg::stat_t stat,
	output logic           done,
	output tdq_pkg::res_t  result
);

	localparam int NW  = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int LW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int AAW = $clog2(NODES * LEVELS);

	tdq_pkg::req_t req_q;
	logic [NW-1:0] a_r;
	logic [NW-1:0] v_r;
	logic [15:0]   second_w;

	logic [NW-1:0] x_q;
	logic [NW-1:0] y_q;
	logic [NW-1:0] p_q;
	logic [15:0]   da_q;
	logic [15:0]   db_q;
	logic [15:0]   dy_q;
	logic [LW-1:0] lvl_q;
	logic          done_q;
	tdq_pkg::res_t res_q;

	logic [NW-1:0]  depth_raddr;
	logic [15:0]    depth_rdata;
	logic [NW-1:0]  anc_node;
	logic [AAW-1:0] anc_raddr;
	logic [AAW-1:0] anc_waddr;
	logic [NW-1:0]  anc_rdata;

	logic [16:0] sum_w;
	logic [16:0] twice_w;
	logic [16:0] dist_w;

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= req_in;
		end
	end

	assign second_w = (req_q.op == tdq_pkg::OP_QUERY) ? req_q.node_b : req_q.write_value;

	tdq_node_mod #(.NODES(NODES)) u_mod_a (
		.clk   (clk),
		.value (req_q.node_a),
		.node  (a_r)
	);

	tdq_node_mod #(.NODES(NODES)) u_mod_b (
		.clk   (clk),
		.value (second_w),
		.node  (v_r)
	);

	always_comb begin
		case (cmd.dsel)
			tdq_pkg::DS_A:   depth_raddr = a_r;
			tdq_pkg::DS_B:   depth_raddr = v_r;
			tdq_pkg::DS_ANC: depth_raddr = anc_rdata;
			default:         depth_raddr = x_q;
		endcase
	end

	assign anc_node  = (cmd.asel == tdq_pkg::AS_Y) ? y_q : x_q;
	assign anc_raddr = AAW'(anc_node) * AAW'(LEVELS) + AAW'(lvl_q);
	assign anc_waddr = AAW'(a_r) * AAW'(LEVELS) + AAW'(req_q.lift_level[LW-1:0]);

	tdq_ram #(.WIDTH(16), .DEPTH(NODES)) u_depth (
		.clk   (clk),
		.we    (cmd.wr_depth),
		.waddr (a_r),
		.wdata (req_q.write_value),
		.re    (cmd.rd_depth),
		.raddr (depth_raddr),
		.rdata (depth_rdata)
	);

	tdq_ram #(.WIDTH(NW), .DEPTH(NODES * LEVELS)) u_anc (
		.clk   (clk),
		.we    (cmd.wr_anc),
		.waddr (anc_waddr),
		.wdata (v_r),
		.re    (cmd.rd_anc),
		.raddr (anc_raddr),
		.rdata (anc_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.cap_da) begin
			da_q <= depth_rdata;
		end
		if (cmd.swap) begin
			db_q <= depth_rdata;
			if (da_q < depth_rdata) begin
				x_q  <= v_r;
				y_q  <= a_r;
				dy_q <= da_q;
			end else begin
				x_q  <= a_r;
				y_q  <= v_r;
				dy_q <= depth_rdata;
			end
		end
		if (cmd.p_cap) begin
			p_q <= anc_rdata;
		end
		if (cmd.lift1 && (depth_rdata >= dy_q)) begin
			x_q <= p_q;
		end
		if (cmd.lift2 && (p_q != anc_rdata)) begin
			x_q <= p_q;
			y_q <= anc_rdata;
		end
		if (cmd.parent) begin
			x_q <= anc_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q <= '0;
		end else if (cmd.lvl_init) begin
			lvl_q <= LW'(LEVELS - 1);
		end else if (cmd.lvl_dec) begin
			lvl_q <= lvl_q - 1'b1;
		end
	end

	assign sum_w   = 17'(da_q) + 17'(db_q);
	assign twice_w = {depth_rdata, 1'b0};
	assign dist_w  = (sum_w >= twice_w) ? (sum_w - twice_w) : '0;

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_q.distance        <= dist_w;
			res_q.common_ancestor <= 16'(x_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	assign done   = done_q;
	assign result = res_q;

	assign stat.op       = req_q.op;
	assign stat.lvl_ok   = (int'(req_q.lift_level) < LEVELS);
	assign stat.lvl_zero = (lvl_q == '0);
	assign stat.xy_ne    = (x_q != y_q);

	a_done_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(cmd.finish))
		else $error("result strobe without finish");

	a_y_fixed_pass1: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.lift1 |=> $stable(y_q))
		else $error("shallow node moved during depth lift");

endmodule

/* rtl/core/tree_distance_query.sv */
// ----------------------------------------------------------------------------
// tree_distance_query: path length and lowest common ancestor by binary lifting
//
//   channel   ports                    handshake
//   request   request (req_t)          start & !busy
//   result    result (res_t)           done, one cycle, no back-pressure
//
// Depth load: busy from accept through the reduction and write states.
// Ancestor load: same as a depth load.
// Query: busy through reduction, depth reads, both lifting passes, an optional
// parent step and a depth read; done pulses in the first cycle with busy low.
// The second pass reads x then y over the ancestor table's single read port.
// Reset clears state_q, lvl_q and done_q; stores are undefined until written.
// Results cannot be held off; a new request may be accepted while done is high.
// ----------------------------------------------------------------------------
module tree_distance_query #(
	parameter int NODES  = 65536,
	parameter int LEVELS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  tdq_pkg::req_t request,
	output logic          done,
	output tdq_pkg::res_t result
);

	tdq_pkg::cmd_t  cmd;
	tdq_pkg::stat_t stat;

	tdq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	tdq_datapath #(.NODES(NODES), .LEVELS(LEVELS)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req_in (request),
		.stat   (stat),
		.done   (done),
		.result (result)
	);

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for tree_distance_query
// Loads random trees (bushy, chain-like and scrambled pointer sets) node by
// node, fires distance queries between their members with stray loads and
// unused opcodes mixed in, and checks every result against a binary-lifting
// predictor updated at each accepted request.
// ----------------------------------------------------------------------------
module testbench;

	localparam int NODES         = 65536;
	localparam int LEVELS        = 16;
	localparam int MAX_TREE      = 32;
	localparam int SETTLE_CYCLES = 6 * LEVELS + 16;
	localparam int DRAIN_LIMIT   = 4000;
	localparam int CYCLE_LIMIT   = 1000000;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef enum {SHAPE_BUSHY, SHAPE_CHAIN, SHAPE_SCRAMBLED} shape_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	tdq_pkg::req_t request;
	tdq_pkg::res_t result;

	tdq_pkg::req_t request_q [$];
	tdq_pkg::res_t expected_answers [$];
	logic [15:0] tree_node [$];
	logic [15:0] depth_mem [int unsigned];
	logic [15:0] anc_mem [int unsigned];

	int accept_count;
	int issue_count;
	int gap_left;
	bit quiet;
	int mismatch_count;
	int cycle_count;

	tree_distance_query #(
		.NODES (NODES),
		.LEVELS(LEVELS)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.request(request),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ---------------- predictor ----------------

	function automatic logic [15:0] stored_depth(input logic [15:0] node);
		return depth_mem.exists(int'(node)) ? depth_mem[int'(node)] : 16'd0;
	endfunction

	function automatic logic [15:0] jump(input logic [15:0] node, input int level);
		int unsigned key;
		key = int'(node) * LEVELS + level;
		return anc_mem.exists(key) ? anc_mem[key] : 16'd0;
	endfunction

	function automatic tdq_pkg::res_t lca_distance(input logic [15:0] na,
		input logic [15:0] nb);
		logic [15:0] x, y, t, px, py;
		int i;
		int path_len;
		tdq_pkg::res_t r;
		x = na;
		y = nb;
		if (stored_depth(x) < stored_depth(y)) begin
			t = x;
			x = y;
			y = t;
		end
		for (i = LEVELS - 1; i >= 0; i--) begin
			px = jump(x, i);
			if (stored_depth(px) >= stored_depth(y))
				x = px;
		end
		for (i = LEVELS - 1; i >= 0; i--) begin
			px = jump(x, i);
			py = jump(y, i);
			if (px != py) begin
				x = px;
				y = py;
			end
		end
		if (x != y)
			x = jump(x, 0);
		path_len = int'(stored_depth(na)) + int'(stored_depth(nb))
			- 2 * int'(stored_depth(x));
		if (path_len < 0)
			path_len = 0;
		r.distance        = 17'(path_len);
		r.common_ancestor = x;
		return r;
	endfunction

	task automatic apply_request(input tdq_pkg::req_t rq);
		case (rq.op)
			tdq_pkg::OP_WR_DEPTH: depth_mem[int'(rq.node_a)] = rq.write_value;
			tdq_pkg::OP_WR_ANC: begin
				if (int'(rq.lift_level) < LEVELS)
					anc_mem[int'(rq.node_a) * LEVELS + int'(rq.lift_level)] = rq.write_value;
			end
			tdq_pkg::OP_QUERY: expected_answers.push_back(lca_distance(rq.node_a, rq.node_b));
			default: ;
		endcase
	endtask

	task automatic check_result(input tdq_pkg::res_t got);
		tdq_pkg::res_t want;
		if (expected_answers.size() == 0) begin
			$error("result with no query pending: distance %0d, common_ancestor %h",
				got.distance, got.common_ancestor);
			mismatch_count++;
		end else begin
			want = expected_answers.pop_front();
			if (got.distance !== want.distance) begin
				$error("distance: expected %0d, actual %0d", want.distance, got.distance);
				mismatch_count++;
			end
			if (got.common_ancestor !== want.common_ancestor) begin
				$error("common_ancestor: expected %h, actual %h",
					want.common_ancestor, got.common_ancestor);
				mismatch_count++;
			end
		end
	endtask

	// ---------------- stimulus ----------------

	function automatic logic [15:0] rnd16();
		return 16'($urandom);
	endfunction

	function automatic bit in_tree(input logic [15:0] node);
		foreach (tree_node[i])
			if (tree_node[i] == node)
				return 1'b1;
		return 1'b0;
	endfunction

	task automatic push_item(input logic [1:0] op, input logic [15:0] a, input logic [15:0] b,
		input logic [3:0] lvl, input logic [15:0] val);
		tdq_pkg::req_t rq;
		rq.op          = op;
		rq.node_a      = a;
		rq.node_b      = b;
		rq.lift_level  = lvl;
		rq.write_value = val;
		request_q.push_back(rq);
	endtask

	// stray traffic never touches nodes of the live tree
	task automatic push_noise();
		logic [15:0] stray;
		stray = rnd16();
		while (in_tree(stray))
			stray = rnd16();
		case ($urandom_range(0, 2))
			0: push_item(OP_UNUSED, rnd16(), rnd16(), 4'($urandom), rnd16());
			1: push_item(tdq_pkg::OP_WR_DEPTH, stray, rnd16(), 4'($urandom), rnd16());
			default: push_item(tdq_pkg::OP_WR_ANC, stray, rnd16(), 4'($urandom), rnd16());
		endcase
	endtask

	task automatic load_tree(input int n, input shape_t shape);
		int up_ix [MAX_TREE][LEVELS];
		logic [15:0] dep [MAX_TREE];
		logic [15:0] cand;
		int base;
		int i, k;
		tree_node.delete();
		while (tree_node.size() < n) begin
			cand = rnd16();
			if (!in_tree(cand))
				tree_node.push_back(cand);
		end
		base = $urandom_range(0, 65535 - n);
		for (i = 0; i < n; i++) begin
			if (shape == SHAPE_SCRAMBLED) begin
				for (k = 0; k < LEVELS; k++)
					up_ix[i][k] = $urandom_range(0, n - 1);
				dep[i] = rnd16();
			end else begin
				if (i == 0)
					up_ix[i][0] = 0;
				else if (shape == SHAPE_CHAIN && $urandom_range(0, 3) != 0)
					up_ix[i][0] = i - 1;
				else
					up_ix[i][0] = $urandom_range(0, i - 1);
				dep[i] = (i == 0) ? 16'(base) : dep[up_ix[i][0]] + 16'd1;
				for (k = 1; k < LEVELS; k++)
					up_ix[i][k] = up_ix[up_ix[i][k - 1]][k - 1];
			end
		end
		for (i = 0; i < n; i++) begin
			push_item(tdq_pkg::OP_WR_DEPTH, tree_node[i], rnd16(), 4'($urandom), dep[i]);
			for (k = 0; k < LEVELS; k++)
				push_item(tdq_pkg::OP_WR_ANC, tree_node[i], rnd16(), 4'(k),
					tree_node[up_ix[i][k]]);
			if ($urandom_range(0, 3) == 0)
				push_noise();
		end
	endtask

	task automatic add_queries(input int count);
		int q;
		int last;
		last = tree_node.size() - 1;
		for (q = 0; q < count; q++) begin
			if ($urandom_range(0, 9) == 0)
				push_noise();
			push_item(tdq_pkg::OP_QUERY, tree_node[$urandom_range(0, last)],
				tree_node[$urandom_range(0, last)], 4'($urandom), rnd16());
		end
	endtask

	task automatic load_directed();
		int i, k;
		tree_node.delete();
		tree_node.push_back(16'h0000);
		tree_node.push_back(16'hFFFF);
		tree_node.push_back(16'h5555);
		// root at depth 0, two leaves at the deepest depth, all levels to the root
		for (i = 0; i < 3; i++) begin
			push_item(tdq_pkg::OP_WR_DEPTH, tree_node[i], 16'h0000, 4'hF,
				(i == 0) ? 16'h0000 : 16'hFFFF);
			for (k = 0; k < LEVELS; k++)
				push_item(tdq_pkg::OP_WR_ANC, tree_node[i], 16'hFFFF, 4'(k), 16'h0000);
		end
		push_item(tdq_pkg::OP_QUERY, 16'hFFFF, 16'h5555, 4'h0, 16'h0000);
		push_item(tdq_pkg::OP_QUERY, 16'h5555, 16'hFFFF, 4'hF, 16'hFFFF);
		push_item(tdq_pkg::OP_QUERY, 16'hFFFF, 16'hFFFF, 4'h0, 16'h0000);
		push_item(tdq_pkg::OP_QUERY, 16'h0000, 16'h0000, 4'h0, 16'h0000);
		push_item(tdq_pkg::OP_QUERY, 16'hFFFF, 16'h0000, 4'h0, 16'h0000);
		push_item(tdq_pkg::OP_QUERY, 16'h0000, 16'h5555, 4'h0, 16'h0000);
		push_item(OP_UNUSED, 16'hFFFF, 16'hFFFF, 4'hF, 16'hFFFF);
		push_item(tdq_pkg::OP_QUERY, 16'h5555, 16'h0000, 4'h0, 16'h0000);
		// root deeper than the leaves: distance saturates at zero
		push_item(tdq_pkg::OP_WR_DEPTH, 16'h0000, 16'h0000, 4'h0, 16'hFFFF);
		push_item(tdq_pkg::OP_WR_DEPTH, 16'hFFFF, 16'h0000, 4'h0, 16'h0000);
		push_item(tdq_pkg::OP_WR_DEPTH, 16'h5555, 16'h0000, 4'h0, 16'h0000);
		push_item(tdq_pkg::OP_QUERY, 16'hFFFF, 16'h5555, 4'h0, 16'h0000);
		push_item(tdq_pkg::OP_QUERY, 16'h0000, 16'hFFFF, 4'h0, 16'h0000);
	endtask

	// ---------------- request driver ----------------

	always @(negedge clk) begin
		logic nxt_start;
		nxt_start = 1'b0;
		if (arst_n) begin
			nxt_start = start;
			if (start && accept_count == issue_count) begin
				nxt_start = 1'b0;
				if ($urandom_range(0, 63) == 0)
					quiet = ~quiet;
				gap_left = quiet ? 0 : $urandom_range(0, 5);
			end
			if (!nxt_start) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (request_q.size() != 0) begin
					request <= request_q.pop_front();
					nxt_start = 1'b1;
					issue_count++;
				end
			end
		end
		start <= nxt_start;
	end

	// ---------------- accept tracking and result check ----------------

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				apply_request(request);
				accept_count++;
			end
			if (done)
				check_result(result);
		end
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	// ---------------- sequence ----------------

	initial begin
		int drain;
		arst_n         = 1'b0;
		start          = 1'b0;
		request        = '0;
		accept_count   = 0;
		issue_count    = 0;
		gap_left       = 0;
		quiet          = 1'b0;
		mismatch_count = 0;
		cycle_count    = 0;

		load_directed();
		load_tree(8, SHAPE_BUSHY);
		add_queries(80);
		load_tree(20, SHAPE_CHAIN);
		add_queries(140);
		load_tree(10, SHAPE_SCRAMBLED);
		add_queries(130);
		load_tree(10, SHAPE_BUSHY);
		add_queries(100);

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		while (request_q.size() != 0 || start)
			@(posedge clk);
		drain = 0;
		while (expected_answers.size() != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_answers.size() != 0) begin
			$error("%0d query results never arrived", expected_answers.size());
			mismatch_count++;
		end

		if (mismatch_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/tdq_pkg.sv
rtl/core/tdq_ram.sv
rtl/core/tdq_node_mod.sv
rtl/core/tdq_ctrl.sv
rtl/core/tdq_datapath.sv
rtl/core/tree_distance_query.sv
verif/testbench.sv
